@@ rtl/scmc_pkg.sv @@
package scmc_pkg;

  // Event codes carried on the command field.
  localparam logic [1:0] CMD_BYTE   = 2'd0;
  localparam logic [1:0] CMD_TICK   = 2'd1;
  localparam logic [1:0] CMD_PULSE  = 2'd2;
  localparam logic [1:0] CMD_SENSOR = 2'd3;

  // Frame command codes (ASCII).
  localparam logic [7:0] CODE_STOP  = 8'h73;
  localparam logic [7:0] CODE_FWD   = 8'h66;
  localparam logic [7:0] CODE_BKW   = 8'h62;
  localparam logic [7:0] CODE_LEFT  = 8'h6C;
  localparam logic [7:0] CODE_RIGHT = 8'h72;

  // H-bridge patterns: fwd R, bkw R, fwd L, bkw L.
  localparam logic [3:0] PAT_FWD   = 4'b1010;
  localparam logic [3:0] PAT_BKW   = 4'b0101;
  localparam logic [3:0] PAT_LEFT  = 4'b0110;
  localparam logic [3:0] PAT_RIGHT = 4'b1001;
  localparam logic [3:0] PAT_OFF   = 4'b0000;

  // Status codes.
  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_BAD_HDR  = 2'd1;
  localparam logic [1:0] STAT_BAD_CODE = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] REG_HEADER  = 2'd0;
  localparam logic [1:0] REG_TIMEOUT = 2'd1;
  localparam logic [1:0] REG_PULSES  = 2'd2;

  typedef struct packed {
    logic [7:0] header_value;
    logic [7:0] timeout_ticks;
    logic [7:0] pulse_limit;
  } cfg_t;

  typedef struct packed {
    logic [3:0] bridge_pattern;
    logic [7:0] duty_left;
    logic [7:0] duty_right;
    logic       drive_enabled;
    logic [1:0] status_code;
    logic [7:0] frame_count;
  } result_t;

endpackage

@@ rtl/scmc_cfg.sv @@
module scmc_cfg
  import scmc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       wr_en,
  input  logic [1:0] wr_index,
  input  logic [7:0] wr_data,
  output cfg_t       cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.header_value  <= 8'd72;
      cfg.timeout_ticks <= 8'd110;
      cfg.pulse_limit   <= 8'd30;
    end else if (wr_en) begin
      case (wr_index)
        REG_HEADER:  cfg.header_value  <= wr_data;
        REG_TIMEOUT: cfg.timeout_ticks <= wr_data;
        REG_PULSES:  cfg.pulse_limit   <= wr_data;
        default: ;
      endcase
    end
  end

endmodule

@@ rtl/scmc_core.sv @@
module scmc_core
  import scmc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       cfg,
  input  logic       take,
  input  logic [1:0] command,
  input  logic [7:0] rx_byte,
  input  logic       front_clear,
  input  logic       rear_clear,
  output result_t    result
);

  localparam logic [1:0] PH_HEADER = 2'd0;
  localparam logic [1:0] PH_CODE   = 2'd1;
  localparam logic [1:0] PH_LEFT   = 2'd2;
  localparam logic [1:0] PH_RIGHT  = 2'd3;

  logic [1:0] parse_phase, parse_phase_next;
  logic [7:0] held_code, held_code_next;
  logic [7:0] held_left, held_left_next;
  logic [7:0] run_tick_count, run_tick_count_next;
  logic       timer_running, timer_running_next;
  logic [7:0] pulse_count, pulse_count_next;
  logic [3:0] pattern, pattern_next;
  logic [7:0] duty_l, duty_l_next;
  logic [7:0] duty_r, duty_r_next;
  logic       enabled, enabled_next;
  logic [1:0] error_flag, error_flag_next;
  logic [7:0] frames_done, frames_done_next;

  logic [7:0] tick_inc;
  logic [7:0] pulse_inc;
  logic       halt;
  logic       start;
  logic [3:0] start_pattern;

  assign tick_inc  = run_tick_count + 8'd1;
  assign pulse_inc = pulse_count + 8'd1;

  always_comb begin
    parse_phase_next    = parse_phase;
    held_code_next      = held_code;
    held_left_next      = held_left;
    run_tick_count_next = run_tick_count;
    timer_running_next  = timer_running;
    pulse_count_next    = pulse_count;
    error_flag_next     = error_flag;
    frames_done_next    = frames_done;
    halt                = 1'b0;
    start               = 1'b0;
    start_pattern       = PAT_OFF;

    case (command)
      CMD_BYTE: begin
        case (parse_phase)
          PH_HEADER: begin
            if (rx_byte == cfg.header_value) begin
              parse_phase_next = PH_CODE;
            end else begin
              error_flag_next = STAT_BAD_HDR;
            end
          end
          PH_CODE: begin
            held_code_next   = rx_byte;
            parse_phase_next = PH_LEFT;
          end
          PH_LEFT: begin
            held_left_next   = rx_byte;
            parse_phase_next = PH_RIGHT;
          end
          default: begin
            parse_phase_next = PH_HEADER;
            frames_done_next = frames_done + 8'd1;
            error_flag_next  = STAT_OK;
            case (held_code)
              CODE_STOP:  halt = 1'b1;
              CODE_FWD: begin
                start = 1'b1; start_pattern = PAT_FWD;
              end
              CODE_BKW: begin
                start = 1'b1; start_pattern = PAT_BKW;
              end
              CODE_LEFT: begin
                start = 1'b1; start_pattern = PAT_LEFT;
              end
              CODE_RIGHT: begin
                start = 1'b1; start_pattern = PAT_RIGHT;
              end
              default: error_flag_next = STAT_BAD_CODE;
            endcase
          end
        endcase
      end
      CMD_TICK: begin
        if (timer_running) begin
          run_tick_count_next = tick_inc;
          if (tick_inc >= cfg.timeout_ticks) begin
            halt = 1'b1;
          end
        end
      end
      CMD_PULSE: begin
        pulse_count_next = pulse_inc;
        if (pulse_inc >= cfg.pulse_limit) begin
          halt             = 1'b1;
          pulse_count_next = 8'd0;
        end
      end
      default: begin
        if (!front_clear || !rear_clear) begin
          halt = 1'b1;
        end
      end
    endcase

    pattern_next = pattern;
    duty_l_next  = duty_l;
    duty_r_next  = duty_r;
    enabled_next = enabled;
    if (halt) begin
      timer_running_next  = 1'b0;
      run_tick_count_next = 8'd0;
      enabled_next        = 1'b0;
      pattern_next        = PAT_OFF;
    end else if (start) begin
      timer_running_next  = 1'b1;
      run_tick_count_next = 8'd0;
      enabled_next        = 1'b1;
      pattern_next        = start_pattern;
      duty_l_next         = held_left;
      duty_r_next         = rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      parse_phase    <= PH_HEADER;
      held_code      <= 8'd0;
      held_left      <= 8'd0;
      run_tick_count <= 8'd0;
      timer_running  <= 1'b0;
      pulse_count    <= 8'd0;
      pattern        <= PAT_OFF;
      duty_l         <= 8'd0;
      duty_r         <= 8'd0;
      enabled        <= 1'b0;
      error_flag     <= STAT_OK;
      frames_done    <= 8'd0;
    end else if (take) begin
      parse_phase    <= parse_phase_next;
      held_code      <= held_code_next;
      held_left      <= held_left_next;
      run_tick_count <= run_tick_count_next;
      timer_running  <= timer_running_next;
      pulse_count    <= pulse_count_next;
      pattern        <= pattern_next;
      duty_l         <= duty_l_next;
      duty_r         <= duty_r_next;
      enabled        <= enabled_next;
      error_flag     <= error_flag_next;
      frames_done    <= frames_done_next;
    end
  end

  // The result shows the state as it stands after this event.
  always_comb begin
    result.bridge_pattern = pattern_next;
    result.duty_left      = duty_l_next;
    result.duty_right     = duty_r_next;
    result.drive_enabled  = enabled_next;
    result.status_code    = error_flag_next;
    result.frame_count    = frames_done_next;
  end

endmodule

@@ rtl/scmc_out_buf.sv @@
module scmc_out_buf
  import scmc_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  result_t push_data,
  output logic    full,
  output logic    out_valid,
  input  logic    out_stall,
  output result_t out_data
);

  logic    main_valid;
  logic    skid_valid;
  result_t skid_data;
  logic    pop;

  assign pop       = main_valid && !out_stall;
  assign full      = skid_valid;
  assign out_valid = main_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (!main_valid || pop) begin
        main_valid <= skid_valid || push;
        skid_valid <= 1'b0;
      end else if (push) begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!main_valid || pop) begin
      out_data <= skid_valid ? skid_data : push_data;
    end
    if (push && main_valid && !pop) begin
      skid_data <= push_data;
    end
  end

endmodule

@@ rtl/serial_command_motor_controller_unit.sv @@
// Serial command motor controller: frame parser, run timer, encoder limit and obstacle stop.
// A transaction's result is written into the output buffer on the edge that accepts it.
// Throughput: one transaction per cycle while in_stall is low; the state update is one pass of logic.
// A two-entry output buffer lets the input keep moving while a result waits.
// Reset (rst, synchronous, active high) idles the drive, clears counters and empties the
// output buffer; the registers return to header 72, timeout 110 and pulse limit 30.
module serial_command_motor_controller_unit
  import scmc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  // Configuration write channel; writes are always taken.
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data,
  // Event input channel.
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] command,
  input  logic [7:0] rx_byte,
  input  logic       front_clear,
  input  logic       rear_clear,
  // Result channel.
  output logic       out_valid,
  input  logic       out_stall,
  output logic [3:0] bridge_pattern,
  output logic [7:0] duty_left,
  output logic [7:0] duty_right,
  output logic       drive_enabled,
  output logic [1:0] status_code,
  output logic [7:0] frame_count
);

  cfg_t    cfg;
  result_t next_result;
  result_t held_result;
  logic    take;
  logic    buf_full;

  assign cfg_ready = 1'b1;

  // The input is held off only while the skid entry is occupied, so the
  // stall seen by the sender always comes straight from a register.
  assign in_stall = buf_full;
  assign take     = in_valid && !buf_full;

  scmc_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // All per-event work happens here in one pass of logic; the state
  // registers commit on the same edge that writes the result into the output buffer.
  scmc_core u_core (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .take        (take),
    .command     (command),
    .rx_byte     (rx_byte),
    .front_clear (front_clear),
    .rear_clear  (rear_clear),
    .result      (next_result)
  );

  scmc_out_buf u_out (
    .clk       (clk),
    .rst       (rst),
    .push      (take),
    .push_data (next_result),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (held_result)
  );

  assign bridge_pattern = held_result.bridge_pattern;
  assign duty_left      = held_result.duty_left;
  assign duty_right     = held_result.duty_right;
  assign drive_enabled  = held_result.drive_enabled;
  assign status_code    = held_result.status_code;
  assign frame_count    = held_result.frame_count;

  // The skid entry only fills behind an occupied output register.
  assert property (@(posedge clk) disable iff (rst) in_stall |-> out_valid)
    else $error("skid entry occupied while output register is empty");

  // A driven bridge always comes with PWM enabled, and a stop clears both.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (drive_enabled == (bridge_pattern != PAT_OFF)))
    else $error("bridge pattern and drive enable disagree");

  // Reset empties the output side.
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

endmodule
